// ===== rtl/core/rdsm_pkg.sv =====
// Shared types and constants for the rotated diagonal stretch matrix unit.
package rdsm_pkg;

    localparam int SW = 32;   // stretch width, Q16.16
    localparam int VW = 31;   // clamped stretch width
    localparam int NW = 93;   // divider numerator / denominator width
    localparam int QW = 60;   // quotient bits produced by the divider
    localparam int DW = 61;   // signed diagonal value width, Q37.24
    localparam int OW = 48;   // result entry width
    localparam int PW = 32;   // rotation product width, Q4.28
    localparam int NP = 6;    // distinct entries of a symmetric 3x3

    typedef enum logic [1:0] {
        MODE_MAT = 2'd0,
        MODE_INV = 2'd1,
        MODE_D1  = 2'd2,
        MODE_D2  = 2'd3
    } t_mode;

    localparam logic [1:0] CFG_ROW0 = 2'd0;
    localparam logic [1:0] CFG_ROW1 = 2'd1;
    localparam logic [1:0] CFG_ROW2 = 2'd2;
    localparam logic [1:0] CFG_THR  = 2'd3;

    localparam logic [QW-1:0] DIAG_LIMIT = {1'b1, {(QW-1){1'b0}}};

    // pair e covers entry (PAIR_A[e], PAIR_B[e]) and its mirror
    localparam logic [1:0] PAIR_A [NP] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] PAIR_B [NP] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};
    localparam logic [2:0] ENTRY_PAIR [9] =
        '{3'd0, 3'd1, 3'd2, 3'd1, 3'd3, 3'd4, 3'd2, 3'd4, 3'd5};

    typedef struct packed {
        t_mode             mode;
        logic [1:0]        idx_i;
        logic [1:0]        idx_j;
        logic [2:0][SW-1:0] stretch;
    } t_side;

    typedef struct packed {
        logic [NW-1:0] den;
        logic [NW-1:0] rem;
        logic [QW-1:0] num_lo;
        logic [QW-1:0] q;
        logic          ovf;
    } t_div;

endpackage

// ===== rtl/core/rdsm_prep.sv =====
// Front end: threshold clamp, stretch powers and divider operand selection.
module rdsm_prep (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  rdsm_pkg::t_side               i_side,
    input  logic [rdsm_pkg::VW-1:0]       i_thr,
    output logic                          o_vld,
    output rdsm_pkg::t_side               o_side,
    output logic [rdsm_pkg::NW-1:0]       o_den [3],
    output logic [rdsm_pkg::NW-1:0]       o_num [3]
);
    import rdsm_pkg::*;

    logic [4:0]      r_vld;
    t_side           r_side [5];
    logic [VW-1:0]   r0_v [3];
    logic [VW-1:0]   r1_v [3];
    logic [2*VW-1:0] r1_v2 [3];
    logic [VW-1:0]   r2_v [3];
    logic [2*VW-1:0] r2_v2 [3];
    logic [2*VW-1:0] r2_ph [3];
    logic [2*VW-1:0] r2_pl [3];
    logic [VW-1:0]   r3_v [3];
    logic [2*VW-1:0] r3_v2 [3];
    logic [NW-1:0]   r3_v3 [3];
    logic [NW-1:0]   r4_den [3];
    logic [NW-1:0]   r4_num [3];
    logic [VW-1:0]   thr_eff;
    logic [VW-1:0]   n_v [3];
    logic [NW-1:0]   n_den [3];
    logic [NW-1:0]   n_num [3];

    always_comb begin
        thr_eff = (i_thr == '0) ? VW'(1) : i_thr;
        for (int k = 0; k < 3; k++) begin
            n_v[k] = ($signed(i_side.stretch[k]) < $signed({1'b0, thr_eff})) ?
                     thr_eff : i_side.stretch[k][VW-1:0];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            case (r_side[3].mode)
                MODE_D1: begin
                    n_den[k] = NW'(r3_v2[k]);
                    n_num[k] = (NW'(1) << 56) + (NW'(r3_v2[k]) >> 1);
                end
                MODE_D2: begin
                    n_den[k] = r3_v3[k];
                    n_num[k] = (NW'(1) << 73) + (r3_v3[k] >> 1);
                end
                default: begin
                    n_den[k] = NW'(r3_v[k]);
                    n_num[k] = (NW'(1) << 40) + (NW'(r3_v[k]) >> 1);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int s = 1; s < 5; s++) r_side[s] <= r_side[s-1];
            for (int k = 0; k < 3; k++) begin
                r0_v[k]   <= n_v[k];
                r1_v[k]   <= r0_v[k];
                r1_v2[k]  <= r0_v[k] * r0_v[k];
                r2_v[k]   <= r1_v[k];
                r2_v2[k]  <= r1_v2[k];
                r2_ph[k]  <= r1_v2[k][2*VW-1:VW] * r1_v[k];
                r2_pl[k]  <= r1_v2[k][VW-1:0] * r1_v[k];
                r3_v[k]   <= r2_v[k];
                r3_v2[k]  <= r2_v2[k];
                r3_v3[k]  <= (NW'(r2_ph[k]) << VW) + NW'(r2_pl[k]);
                r4_den[k] <= n_den[k];
                r4_num[k] <= n_num[k];
            end
        end
    end

    assign o_vld  = r_vld[4];
    assign o_side = r_side[4];
    assign o_den  = r4_den;
    assign o_num  = r4_num;

endmodule

// ===== rtl/core/rdsm_div.sv =====
// Pipelined restoring divider, three lanes, one quotient bit per stage.
module rdsm_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  rdsm_pkg::t_side           i_side,
    input  logic [rdsm_pkg::NW-1:0]   i_den [3],
    input  logic [rdsm_pkg::NW-1:0]   i_num [3],
    output logic                      o_vld,
    output rdsm_pkg::t_side           o_side,
    output logic [rdsm_pkg::QW-1:0]   o_q [3],
    output logic                      o_ovf [3]
);
    import rdsm_pkg::*;

    logic [QW:0] r_vld;
    t_side       r_side [QW+1];
    t_div        r_st [QW+1][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW-1:0], i_vld};
        end
    end

    // initial stage: top numerator bits, overflow when quotient needs more than QW bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 0; k < 3; k++) begin
                r_st[0][k].den    <= i_den[k];
                r_st[0][k].rem    <= NW'(i_num[k][NW-1:QW]);
                r_st[0][k].num_lo <= i_num[k][QW-1:0];
                r_st[0][k].q      <= '0;
                r_st[0][k].ovf    <= NW'(i_num[k][NW-1:QW]) >= i_den[k];
            end
        end
    end

    for (genvar g = 1; g <= QW; g++) begin : g_step
        logic [NW:0] t [3];
        logic        ge [3];

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                t[k]  = {r_st[g-1][k].rem, r_st[g-1][k].num_lo[QW-g]};
                ge[k] = t[k] >= {1'b0, r_st[g-1][k].den};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g] <= r_side[g-1];
                for (int k = 0; k < 3; k++) begin
                    r_st[g][k].den    <= r_st[g-1][k].den;
                    r_st[g][k].num_lo <= r_st[g-1][k].num_lo;
                    r_st[g][k].ovf    <= r_st[g-1][k].ovf;
                    r_st[g][k].q      <= {r_st[g-1][k].q[QW-2:0], ge[k]};
                    r_st[g][k].rem    <= ge[k] ? NW'(t[k] - {1'b0, r_st[g-1][k].den})
                                               : t[k][NW-1:0];
                end
            end
        end
    end

    assign o_vld  = r_vld[QW];
    assign o_side = r_side[QW];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_q[k]   = r_st[QW][k].q;
            o_ovf[k] = r_st[QW][k].ovf;
        end
    end

endmodule

// ===== rtl/core/rdsm_combine.sv =====
// Back end: diagonal select, rotation products, sums, rounding and saturation.
module rdsm_combine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_vld,
    input  rdsm_pkg::t_side                  i_side,
    input  logic [rdsm_pkg::QW-1:0]          i_q [3],
    input  logic                             i_ovf [3],
    input  logic signed [rdsm_pkg::PW-1:0]   i_prod [3][rdsm_pkg::NP],
    output logic                             o_vld,
    output logic [rdsm_pkg::OW-1:0]          o_m [9],
    output logic                             o_sat
);
    import rdsm_pkg::*;

    localparam int HW = DW - 28;          // high part of diagonal
    localparam int HPW = HW + PW;
    localparam int HSW = HPW + 2;
    localparam int LPW = 29 + PW;
    localparam int LSW = LPW + 2;
    localparam int RW = HSW + 1;

    logic [3:0]             r_vld;
    logic signed [HW-1:0]   r_dh [3];
    logic [27:0]            r_dl [3];
    logic signed [HPW-1:0]  r_hp [NP][3];
    logic signed [LPW-1:0]  r_lp [NP][3];
    logic signed [HSW-1:0]  r_hs [NP];
    logic signed [LSW-29:0] r_lc [NP];
    logic [OW-1:0]          r_m [NP];
    logic [NP-1:0]          r_sat;

    logic [QW-1:0]          mag [3];
    logic signed [DW-1:0]   n_d [3];
    logic signed [LSW-1:0]  lsum [NP];
    logic signed [RW-1:0]   rsum [NP];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag[k] = (i_ovf[k] || i_q[k] > DIAG_LIMIT) ? DIAG_LIMIT : i_q[k];
            case (i_side.mode)
                MODE_MAT: n_d[k] = DW'($signed({i_side.stretch[k], 8'd0}));
                MODE_INV: n_d[k] = $signed({1'b0, mag[k]});
                MODE_D1:  n_d[k] = (i_side.idx_i == 2'(k)) ? -$signed({1'b0, mag[k]}) : '0;
                MODE_D2:  n_d[k] = (i_side.idx_i == 2'(k) && i_side.idx_j == 2'(k)) ?
                                   $signed({1'b0, mag[k]}) : '0;
                default:  n_d[k] = '0;
            endcase
        end
    end

    always_comb begin
        for (int e = 0; e < NP; e++) begin
            lsum[e] = LSW'(r_lp[e][0]) + LSW'(r_lp[e][1]) + LSW'(r_lp[e][2])
                    + $signed(LSW'(1) << 27);
            rsum[e] = RW'(r_hs[e]) + RW'(r_lc[e]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_dh[k] <= n_d[k][DW-1:28];
                r_dl[k] <= n_d[k][27:0];
            end
            for (int e = 0; e < NP; e++) begin
                for (int k = 0; k < 3; k++) begin
                    r_hp[e][k] <= HPW'(r_dh[k]) * HPW'(i_prod[k][e]);
                    r_lp[e][k] <= $signed({1'b0, r_dl[k]}) * LPW'(i_prod[k][e]);
                end
                r_hs[e] <= HSW'(r_hp[e][0]) + HSW'(r_hp[e][1]) + HSW'(r_hp[e][2]);
                r_lc[e] <= lsum[e][LSW-1:28];
                // clip when the bits above the result sign disagree
                if (rsum[e][RW-1:OW-1] != {(RW-OW+1){rsum[e][RW-1]}}) begin
                    r_m[e]   <= rsum[e][RW-1] ? {1'b1, {(OW-1){1'b0}}}
                                              : {1'b0, {(OW-1){1'b1}}};
                    r_sat[e] <= 1'b1;
                end else begin
                    r_m[e]   <= rsum[e][OW-1:0];
                    r_sat[e] <= 1'b0;
                end
            end
        end
    end

    assign o_vld = r_vld[3];
    assign o_sat = |r_sat;

    always_comb begin
        for (int n = 0; n < 9; n++) o_m[n] = r_m[ENTRY_PAIR[n]];
    end

endmodule

// ===== rtl/core/rotated_diagonal_stretch_matrix_unit.sv =====
// Input to result passes prep, the 60-step divider, combine and the output register.
// Throughput: one item per cycle unless stalled; all stages advance behind one enable.
// A stalled output parks one result in a skid register, then holds every stage
// and the input until the output drains.
// Reset (i_rst_n low at a clock edge) clears all valid bits and loads the identity
// rotation and a threshold of 66.
module rotated_diagonal_stretch_matrix_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [103:0] i_s_tdata,   // stretch0, stretch1, stretch2, index_i, index_j, pad
    input  logic [1:0]   i_s_tuser,   // mode
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [431:0] o_m_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic         o_m_tuser,   // saturated
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [47:0]  i_cfg_data
);
    import rdsm_pkg::*;

    logic [47:0]           r_row [3];
    logic [VW-1:0]         r_thr;
    logic signed [PW-1:0]  r_prod [3][NP];
    logic                  r_out_vld;
    logic [431:0]          r_out_data;
    logic                  r_out_sat;
    logic                  r_skid_vld;
    logic [431:0]          r_skid_data;
    logic                  r_skid_sat;

    logic                  en;
    t_side                 in_side;
    logic                  p_vld;
    t_side                 p_side;
    logic [NW-1:0]         p_den [3];
    logic [NW-1:0]         p_num [3];
    logic                  d_vld;
    t_side                 d_side;
    logic [QW-1:0]         d_q [3];
    logic                  d_ovf [3];
    logic                  c_vld;
    logic [OW-1:0]         c_m [9];
    logic                  c_sat;
    logic [431:0]          c_data;
    logic                  take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= 48'd16384;
            r_row[1] <= 48'd1073741824;
            r_row[2] <= 48'd70368744177664;
            r_thr    <= VW'(66);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ROW0: r_row[0] <= i_cfg_data;
                CFG_ROW1: r_row[1] <= i_cfg_data;
                CFG_ROW2: r_row[2] <= i_cfg_data;
                CFG_THR:  r_thr    <= i_cfg_data[VW-1:0];
                default:  r_thr    <= r_thr;
            endcase
        end
    end

    // rotation products R[k][a]*R[k][b], exact Q4.28
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            for (int e = 0; e < NP; e++) begin
                r_prod[k][e] <= $signed(r_row[k][16*PAIR_A[e] +: 16])
                              * $signed(r_row[k][16*PAIR_B[e] +: 16]);
            end
        end
    end

    assign en         = !r_skid_vld;
    assign o_s_tready = en;

    always_comb begin
        in_side.mode       = t_mode'(i_s_tuser);
        in_side.stretch[0] = i_s_tdata[31:0];
        in_side.stretch[1] = i_s_tdata[63:32];
        in_side.stretch[2] = i_s_tdata[95:64];
        in_side.idx_i      = i_s_tdata[97:96];
        in_side.idx_j      = i_s_tdata[99:98];
    end

    rdsm_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_tvalid),
        .i_side  (in_side),
        .i_thr   (r_thr),
        .o_vld   (p_vld),
        .o_side  (p_side),
        .o_den   (p_den),
        .o_num   (p_num)
    );

    rdsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (p_vld),
        .i_side  (p_side),
        .i_den   (p_den),
        .i_num   (p_num),
        .o_vld   (d_vld),
        .o_side  (d_side),
        .o_q     (d_q),
        .o_ovf   (d_ovf)
    );

    rdsm_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (d_vld),
        .i_side  (d_side),
        .i_q     (d_q),
        .i_ovf   (d_ovf),
        .i_prod  (r_prod),
        .o_vld   (c_vld),
        .o_m     (c_m),
        .o_sat   (c_sat)
    );

    always_comb begin
        for (int n = 0; n < 9; n++) c_data[OW*n +: OW] = c_m[n];
    end

    // last pipeline stage hands its result over whenever the pipe advances
    assign take = c_vld && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (!r_out_vld || i_m_tready) begin
                r_out_vld  <= r_skid_vld || take;
                r_skid_vld <= 1'b0;
            end else if (take) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_m_tready) begin
            r_out_data <= r_skid_vld ? r_skid_data : c_data;
            r_out_sat  <= r_skid_vld ? r_skid_sat : c_sat;
        end else if (take) begin
            r_skid_data <= c_data;
            r_skid_sat  <= c_sat;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_sat;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the rotated diagonal stretch matrix unit.
module tb;
    import rdsm_pkg::*;

    typedef struct {
        logic [431:0] entries;
        logic         sat;
    } t_matrix;

    localparam logic signed [127:0] ENTRY_MAX = 128'sh7FFF_FFFF_FFFF;
    localparam logic signed [127:0] ENTRY_MIN = -ENTRY_MAX - 1;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [103:0] i_s_tdata = '0;
    logic [1:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [431:0] o_m_tdata;
    logic         o_m_tuser;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_addr = '0;
    logic [47:0]  i_cfg_data = '0;

    rotated_diagonal_stretch_matrix_unit dut (.*);

    always #4 i_clk = ~i_clk;

    // mirror of the configuration registers
    logic [47:0] rot_row [3] = '{48'd16384, 48'd1073741824, 48'd70368744177664};
    logic [30:0] thr_reg = 31'd66;

    t_matrix pending_matrices [$];
    int          mismatch_cnt = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    // round(2^sh / v^n), clipped at 2^59
    function automatic logic [63:0] recip_round(logic [30:0] v, int n, int sh);
        logic [127:0] den, num, q;
        den = v;
        for (int k = 1; k < n; k++) den = den * v;
        num = (128'd1 << sh) + (den >> 1);
        q = num / den;
        if (q > (128'd1 << 59)) q = 128'd1 << 59;
        return q[63:0];
    endfunction

    function automatic t_matrix predict_matrix(logic [103:0] data, logic [1:0] mode);
        t_matrix m;
        logic signed [31:0]  s;
        logic signed [63:0]  thr, clamped;
        logic signed [63:0]  d [3];
        logic signed [15:0]  ra, rb;
        logic signed [127:0] acc, dw, pw;
        logic [1:0]          ii, jj;
        m.sat = 1'b0;
        m.entries = '0;
        ii = data[97:96];
        jj = data[99:98];
        thr = (thr_reg == 0) ? 64'sd1 : 64'($unsigned(thr_reg));
        for (int k = 0; k < 3; k++) begin
            d[k] = 0;
        end
        for (int k = 0; k < 3; k++) begin
            s = data[32*k +: 32];
            clamped = (64'(s) < thr) ? thr : 64'(s);
            case (t_mode'(mode))
                MODE_MAT: d[k] = 64'(s) * 256;
                MODE_INV: d[k] = recip_round(clamped[30:0], 1, 40);
                MODE_D1: if (ii == k) d[k] = -$signed(recip_round(clamped[30:0], 2, 56));
                default: if (ii == k && jj == k) d[k] = recip_round(clamped[30:0], 3, 73);
            endcase
        end
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) begin
                    ra = rot_row[k][16*a +: 16];
                    rb = rot_row[k][16*b +: 16];
                    dw = d[k];
                    pw = ra * rb;
                    acc = acc + dw * pw;
                end
                acc = (acc + (128'sd1 <<< 27)) >>> 28;
                if (acc > ENTRY_MAX) begin
                    acc = ENTRY_MAX;
                    m.sat = 1'b1;
                end
                if (acc < ENTRY_MIN) begin
                    acc = ENTRY_MIN;
                    m.sat = 1'b1;
                end
                m.entries[48*(3*a+b) +: 48] = acc[47:0];
            end
        end
        return m;
    endfunction

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_matrix exp_m;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_matrices.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result transfer %h", o_m_tdata);
            end else begin
                exp_m = pending_matrices.pop_front();
                for (int e = 0; e < 9; e++) begin
                    if (o_m_tdata[48*e +: 48] !== exp_m.entries[48*e +: 48]) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("entry m%0d%0d: expected %h got %h", e / 3, e % 3,
                                     exp_m.entries[48*e +: 48], o_m_tdata[48*e +: 48]);
                    end
                end
                if (o_m_tuser !== exp_m.sat) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("saturated: expected %b got %b", exp_m.sat, o_m_tuser);
                end
            end
        end
    end

    task automatic send_item(logic [31:0] s0, logic [31:0] s1, logic [31:0] s2,
                             logic [1:0] ii, logic [1:0] jj, t_mode mode);
        logic [103:0] data;
        data = {4'b0, jj, ii, s2, s1, s0};
        @(negedge i_clk);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_tready);
        pending_matrices.push_back(predict_matrix(data, mode));
    endtask

    // stop sending and let the pipeline empty out
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_matrices.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] addr, logic [47:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == CFG_THR) thr_reg = value[30:0];
        else rot_row[addr] = value;
    endtask

    function automatic logic [15:0] rand_rot_entry();
        case ($urandom_range(0, 7))
            0: return 16'h4000;
            1: return 16'hC000;
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_rotation(logic [47:0] r0, logic [47:0] r1, logic [47:0] r2);
        write_cfg(CFG_ROW0, r0);
        write_cfg(CFG_ROW1, r1);
        write_cfg(CFG_ROW2, r2);
    endtask

    task automatic random_rotation();
        logic [47:0] r [3];
        for (int k = 0; k < 3; k++) r[k] = {rand_rot_entry(), rand_rot_entry(), rand_rot_entry()};
        write_rotation(r[0], r[1], r[2]);
    endtask

    function automatic logic [31:0] rand_stretch();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return $urandom_range(0, 40);
            2: return 32'(thr_reg) + $urandom_range(0, 8) - 4;
            3: return -$urandom_range(1, 1 << 20);
            4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            5: return $urandom_range(1 << 14, 1 << 18);
            default: return $urandom_range(0, 1 << 24) - (1 << 23);
        endcase
    endfunction

    task automatic random_items(int n);
        for (int i = 0; i < n; i++) begin
            send_item(rand_stretch(), rand_stretch(), rand_stretch(),
                      $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2)),
                      $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2)),
                      t_mode'($urandom_range(0, 3)));
        end
    endtask

    task automatic test_directed();
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 2'd0, 2'd0, MODE_MAT);
        send_item(32'h0001_0000, 32'hFFFF_FFFF, 32'h1, 2'd3, 2'd3, MODE_MAT);
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 2'd0, 2'd0, MODE_INV);
        send_item(32'd65, 32'd66, 32'd67, 2'd1, 2'd2, MODE_INV);
        send_item(32'h0001_0000, 32'd66, 32'h7FFF_FFFF, 2'd0, 2'd0, MODE_D1);
        send_item(32'h0001_0000, 32'd66, 32'h7FFF_FFFF, 2'd1, 2'd0, MODE_D1);
        send_item(32'h0001_0000, 32'd66, 32'h7FFF_FFFF, 2'd2, 2'd3, MODE_D1);
        send_item(32'h0001_0000, 32'd66, 32'h7FFF_FFFF, 2'd3, 2'd0, MODE_D1);
        send_item(32'h0001_0000, 32'd5, 32'h8000_0000, 2'd0, 2'd0, MODE_D2);
        send_item(32'h0001_0000, 32'd5, 32'h8000_0000, 2'd1, 2'd1, MODE_D2);
        send_item(32'd25, 32'd26, 32'h8000_0000, 2'd2, 2'd2, MODE_D2);
        send_item(32'd25, 32'd26, 32'd1000, 2'd0, 2'd1, MODE_D2);
        send_item(32'd25, 32'd26, 32'd1000, 2'd3, 2'd3, MODE_D2);
        send_item(32'd25, 32'd26, 32'd1000, 2'd2, 2'd3, MODE_D2);
        drain();
        // threshold of zero acts as one LSB, huge reciprocals clip
        write_cfg(CFG_THR, 48'd0);
        send_item(32'h0, 32'h8000_0000, 32'd1, 2'd0, 2'd0, MODE_INV);
        send_item(32'h0, 32'h8000_0000, 32'd1, 2'd1, 2'd1, MODE_D2);
        send_item(32'h0, 32'h8000_0000, 32'd1, 2'd1, 2'd0, MODE_D1);
        drain();
        // extreme rotation entries with full-scale mode 0 stretches; the sums stay inside the output range
        write_rotation(48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h8000_7FFF_8000);
        write_cfg(CFG_THR, 48'h7FFF_FFFF);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 2'd0, 2'd0, MODE_MAT);
        send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 2'd0, 2'd0, MODE_MAT);
        send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 2'd0, 2'd0, MODE_INV);
        send_item(32'h1, 32'h1, 32'h1, 2'd2, 2'd2, MODE_D2);
        drain();
    endtask

    task automatic test_no_idle();
        write_cfg(CFG_THR, 48'd66);
        random_rotation();
        random_items(430);
        drain();
    endtask

    task automatic test_sender_idle();
        write_cfg(CFG_THR, 48'd0);
        random_rotation();
        send_idle_pct = 87;
        random_items(300);
        drain();
        send_idle_pct = 0;
    endtask

    task automatic test_receiver_stall();
        write_cfg(CFG_THR, 48'h7FFF_FFFF);
        random_rotation();
        recv_stall_pct = 87;
        random_items(300);
        drain();
        recv_stall_pct = 0;
    endtask

    task automatic test_both_idle();
        write_cfg(CFG_THR, 48'($urandom_range(1, 1 << 20)));
        random_rotation();
        send_idle_pct = 7;
        recv_stall_pct = 7;
        random_items(150);
        // sender holds off until the pipeline has emptied
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_matrices.size() != 0) @(posedge i_clk);
        random_items(150);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_config_sweep();
        for (int p = 0; p < 4; p++) begin
            write_cfg(CFG_THR, 48'($urandom_range(1, 200)));
            random_rotation();
            send_idle_pct = (p % 2) ? 87 : 0;
            recv_stall_pct = (p >= 2) ? 87 : 0;
            random_items(75);
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_config_sweep();
        if (mismatch_cnt == 0 && pending_matrices.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
